FILE: rtl/rpu_pkg.sv
package rpu_pkg;

    // relocation kinds carried in the operation field
    localparam logic [2:0] OP_ABS32     = 3'd0;
    localparam logic [2:0] OP_PC32      = 3'd1;
    localparam logic [2:0] OP_THUMB_BL  = 3'd2;
    localparam logic [2:0] OP_HI20      = 3'd3;
    localparam logic [2:0] OP_LO12_I    = 3'd4;
    localparam logic [2:0] OP_CALL_PAIR = 3'd5;
    localparam logic [2:0] OP_UNKNOWN   = 3'd6;

    // rounding bias for the upper immediate
    localparam logic [31:0] HI20_ROUND   = 32'h0000_0800;
    // thumb branch base is the instruction address plus four
    localparam logic [31:0] THUMB_PC_ADJ = 32'd4;
    // fixed opcode bits of the two thumb halfwords
    localparam logic [4:0]  THUMB_HW0_OP = 5'b11110;
    localparam logic [1:0]  THUMB_HW1_OP = 2'b11;

    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        symbol_value;
        logic signed [31:0] addend;
        logic [31:0]        place_address;
        logic [31:0]        first_word;
        logic [31:0]        second_word;
    } t_rpu_in;

    typedef struct packed {
        logic [31:0] new_first_word;
        logic [31:0] new_second_word;
        logic        second_written;
        logic        kind_known;
    } t_rpu_out;

endpackage

FILE: rtl/rpu_patch_logic.sv
module rpu_patch_logic (
    input  rpu_pkg::t_rpu_in  i_item,
    output rpu_pkg::t_rpu_out o_result
);
    import rpu_pkg::*;

    logic [31:0] sum;
    logic [31:0] rel;
    logic [31:0] thumb_off;
    logic [31:0] sum_rnd;
    logic [31:0] rel_rnd;
    logic        thumb_s;
    logic        thumb_j1;
    logic        thumb_j2;
    logic [15:0] thumb_hw0;
    logic [15:0] thumb_hw1;

    // shared address arithmetic, all modulo 2^32
    assign sum       = i_item.symbol_value + $unsigned(i_item.addend);
    assign rel       = sum - i_item.place_address;
    assign thumb_off = rel - THUMB_PC_ADJ;
    assign sum_rnd   = sum + HI20_ROUND;
    assign rel_rnd   = rel + HI20_ROUND;

    // thumb-2 bl halfword packing
    assign thumb_s   = thumb_off[24];
    assign thumb_j1  = ~(thumb_off[23] ^ thumb_s);
    assign thumb_j2  = ~(thumb_off[22] ^ thumb_s);
    assign thumb_hw0 = {THUMB_HW0_OP, thumb_s, thumb_off[21:12]};
    assign thumb_hw1 = {THUMB_HW1_OP, thumb_j1, 1'b1, thumb_j2, thumb_off[11:1]};

    // select the patched words by relocation kind
    always_comb begin
        o_result.new_first_word  = i_item.first_word;
        o_result.new_second_word = i_item.second_word;
        o_result.second_written  = 1'b0;
        o_result.kind_known      = 1'b1;
        unique case (i_item.operation)
            OP_ABS32: begin
                o_result.new_first_word = sum;
            end
            OP_PC32: begin
                o_result.new_first_word = rel;
            end
            OP_THUMB_BL: begin
                o_result.new_first_word = {thumb_hw1, thumb_hw0};
            end
            OP_HI20: begin
                o_result.new_first_word = {sum_rnd[31:12], i_item.first_word[11:0]};
            end
            OP_LO12_I: begin
                o_result.new_first_word = {sum[11:0], i_item.first_word[19:0]};
            end
            OP_CALL_PAIR: begin
                o_result.new_first_word  = {rel_rnd[31:12], i_item.first_word[11:0]};
                o_result.new_second_word = {rel[11:0], i_item.second_word[19:0]};
                o_result.second_written  = 1'b1;
            end
            default: begin
                // unknown kind and unused code leave both words as they are
                o_result.kind_known = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/relocation_patch_unit.sv
// relocation patch unit
// applies one relocation per input transfer and returns the patched code
// words. input channel: i_in_valid / o_in_ready with payload i_in_data
// (kind, symbol value, addend, patch address, the two original words).
// output channel: o_out_valid / i_out_ready with payload o_out_data
// (patched words, second-word-written flag, known-kind flag).
// each item passes through the input register and then the result register;
// the patch logic between them is a few 32-bit adders and a field mux.
// throughput: one relocation per cycle, sustained, while the receiver
// takes every result.
// when the receiver stalls, the result register holds its item and the
// input register can still take one more transfer; o_in_ready drops only
// once both registers are full and the output is not being taken.
// reset (synchronous, active low) empties both registers; no result is
// presented until a new input transfer arrives.
module relocation_patch_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rpu_pkg::t_rpu_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rpu_pkg::t_rpu_out o_out_data
);
    import rpu_pkg::*;

    logic     r_in_valid;
    t_rpu_in  r_in_data;
    logic     r_out_valid;
    t_rpu_out r_out_data;
    t_rpu_out patch_result;
    logic     out_free;
    logic     in_advance;
    logic     in_take;

    // result register can load when empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_advance = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // patch computation
    rpu_patch_logic u_patch (
        .i_item   (r_in_data),
        .o_result (patch_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance) begin
            r_out_data <= patch_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // the second word is only patched for a recognized kind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.second_written |-> o_out_data.kind_known)
        else $error("second word patched for unknown relocation kind");

    // both stages full with a stalled receiver must block new input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while pipeline is full and stalled");

    // reset empties the output stage
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a buffered item moves into an empty result register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> o_out_valid)
        else $error("buffered item did not reach the result register");

endmodule
